[hw/rtl/vrr_pkg.sv]
// package for the refraction pipeline: fixed point formats, stage map,
// the pipeline item struct and the per-stage functions
// used by vector_refract_with_reflect, depends on nothing
`default_nettype none

package vrr_pkg;

   localparam int FRAC_BITS = 14;
   localparam int ONE_Q     = 1 << FRAC_BITS;
   localparam longint ONE_SQ   = 64'd1 << (2 * FRAC_BITS);
   localparam longint SMALL_SQ = ONE_SQ / 1000000;
   localparam int HALF_Q    = 1 << (FRAC_BITS - 1);

   // square root: one result bit per stage, divide: one quotient bit per stage
   localparam int SQ_STEPS = 17;
   localparam int DV_STEPS = 15;

   // stage map
   localparam int S_IN  = 0;
   localparam int S_L1  = S_IN + 1;
   localparam int S_SQ1 = S_L1 + 1;
   localparam int S_D1  = S_SQ1 + SQ_STEPS;
   localparam int S_DV1 = S_D1 + 1;
   localparam int S_UN  = S_DV1 + DV_STEPS;
   localparam int S_DOT = S_UN + 1;
   localparam int S_CN  = S_DOT + 1;
   localparam int S_T   = S_CN + 1;
   localparam int S_ET  = S_T + 1;
   localparam int S_P   = S_ET + 1;
   localparam int S_PS  = S_P + 1;
   localparam int S_K   = S_PS + 1;
   localparam int S_SQ2 = S_K + 1;
   localparam int S_SN  = S_SQ2 + SQ_STEPS;
   localparam int S_V   = S_SN + 1;
   localparam int S_VS  = S_V + 1;
   localparam int S_L2  = S_VS + 1;
   localparam int S_SQ3 = S_L2 + 1;
   localparam int S_D2  = S_SQ3 + SQ_STEPS;
   localparam int S_DV2 = S_D2 + 1;
   localparam int S_OUT = S_DV2 + DV_STEPS;
   localparam int NS    = S_OUT + 1;

   typedef logic signed [15:0] s16_type;
   typedef logic signed [36:0] prod_type;
   typedef logic signed [18:0] t_type;
   typedef logic signed [19:0] r_type;
   typedef logic signed [20:0] p_type;
   typedef logic signed [17:0] v_type;
   typedef logic [32:0]        num_type;
   typedef logic [14:0]        q_type;

   typedef struct packed {
      logic               vld;
      s16_type [2:0]      u;
      s16_type [2:0]      n;
      logic [15:0]        eta;
      prod_type [2:0]     pa;
      prod_type [2:0]     pb;
      logic [33:0]        lsq;
      logic [21:0]        rem;
      logic [16:0]        root;
      logic [16:0]        len;
      num_type [2:0]      num;
      q_type [2:0]        q;
      s16_type [2:0]      un;
      logic signed [17:0] d;
      logic signed [17:0] cosv;
      t_type [2:0]        t;
      r_type [2:0]        r;
      p_type [2:0]        p;
      v_type [2:0]        v;
      logic [14:0]        sqk;
      logic               degen;
      logic               tir;
      logic               dgn2;
      s16_type [2:0]      res;
   } pipe_type;

   // shift right by FRAC_BITS, round half away from zero
   function automatic logic signed [39:0] rnd_shr(input logic signed [39:0] a);
      logic [39:0] m;
      m = a[39] ? (~a + 40'd1) : a;
      m = (m + 40'(HALF_Q)) >> FRAC_BITS;
      return a[39] ? (40'd0 - m) : m;
   endfunction

   function automatic logic [20:0] mag21(input logic signed [20:0] a);
      return a[20] ? (~a + 21'd1) : a;
   endfunction

   function automatic s16_type sat16(input r_type a);
      if (a > 20'sd32767)
         return 16'sh7FFF;
      else if (a < -20'sd32768)
         return 16'sh8000;
      else
         return a[15:0];
   endfunction

   function automatic pipe_type f_in(input pipe_type x);
      pipe_type y;
      y = x;
      for (int i = 0; i < 3; i++)
         y.pa[i] = x.u[i] * x.u[i];
      return y;
   endfunction

   function automatic pipe_type f_l1(input pipe_type x);
      pipe_type y;
      prod_type s;
      y = x;
      s = x.pa[0] + x.pa[1] + x.pa[2];
      y.lsq   = s[33:0];
      y.degen = (s <= prod_type'(SMALL_SQ));
      y.rem   = '0;
      y.root  = '0;
      return y;
   endfunction

   // one digit of the integer square root of lsq
   function automatic pipe_type f_sqrt(input pipe_type x, input int k);
      pipe_type y;
      logic [21:0] rm;
      logic [21:0] trial;
      y = x;
      rm    = {x.rem[19:0], x.lsq[33 - 2 * k -: 2]};
      trial = 22'({x.root, 2'b01});
      if (rm >= trial) begin
         y.rem  = rm - trial;
         y.root = {x.root[15:0], 1'b1};
      end else begin
         y.rem  = rm;
         y.root = {x.root[15:0], 1'b0};
      end
      return y;
   endfunction

   function automatic pipe_type f_d1(input pipe_type x);
      pipe_type y;
      logic [20:0] m;
      y = x;
      y.len = x.root;
      for (int i = 0; i < 3; i++) begin
         m = mag21(21'(x.u[i]));
         y.num[i] = (33'(m) << FRAC_BITS) + 33'(x.root >> 1);
         y.q[i]   = '0;
      end
      return y;
   endfunction

   function automatic pipe_type f_d2(input pipe_type x);
      pipe_type y;
      logic [20:0] m;
      y = x;
      y.len = x.root;
      for (int i = 0; i < 3; i++) begin
         m = mag21(21'(x.v[i]));
         y.num[i] = (33'(m) << FRAC_BITS) + 33'(x.root >> 1);
         y.q[i]   = '0;
      end
      return y;
   endfunction

   // one restoring step on quotient bit b of all three lanes
   function automatic pipe_type f_div(input pipe_type x, input int b);
      pipe_type y;
      num_type den;
      y = x;
      den = 33'(x.len) << b;
      for (int i = 0; i < 3; i++) begin
         if (x.num[i] >= den) begin
            y.num[i]  = x.num[i] - den;
            y.q[i][b] = 1'b1;
         end
      end
      return y;
   endfunction

   function automatic pipe_type f_un(input pipe_type x);
      pipe_type y;
      s16_type qq;
      y = x;
      for (int i = 0; i < 3; i++) begin
         qq = {1'b0, x.q[i]};
         if (x.degen)
            y.un[i] = '0;
         else
            y.un[i] = (x.u[i] < 0) ? -qq : qq;
         y.pa[i] = y.un[i] * x.n[i];
      end
      return y;
   endfunction

   function automatic pipe_type f_dot(input pipe_type x);
      pipe_type y;
      logic signed [39:0] rs;
      logic signed [17:0] nd;
      y = x;
      rs = rnd_shr(40'(x.pa[0] + x.pa[1] + x.pa[2]));
      y.d = rs[17:0];
      nd = -rs[17:0];
      y.cosv = (nd > ONE_Q) ? 18'(ONE_Q) : nd;
      return y;
   endfunction

   function automatic pipe_type f_cn(input pipe_type x);
      pipe_type y;
      y = x;
      for (int i = 0; i < 3; i++) begin
         y.pa[i] = x.cosv * x.n[i];
         y.pb[i] = x.d * x.n[i];
      end
      return y;
   endfunction

   function automatic pipe_type f_t(input pipe_type x);
      pipe_type y;
      logic signed [39:0] ta;
      logic signed [39:0] ra;
      y = x;
      for (int i = 0; i < 3; i++) begin
         ta = 40'(x.un[i]) + rnd_shr(40'(x.pa[i]));
         ra = 40'(x.un[i]) - rnd_shr(40'(x.pb[i]) <<< 1);
         y.t[i] = ta[18:0];
         y.r[i] = ra[19:0];
      end
      return y;
   endfunction

   function automatic pipe_type f_et(input pipe_type x);
      pipe_type y;
      y = x;
      for (int i = 0; i < 3; i++)
         y.pa[i] = $signed({1'b0, x.eta}) * x.t[i];
      return y;
   endfunction

   function automatic pipe_type f_p(input pipe_type x);
      pipe_type y;
      logic signed [39:0] pr;
      y = x;
      y.tir = 1'b0;
      for (int i = 0; i < 3; i++) begin
         pr = rnd_shr(40'(x.pa[i]));
         y.p[i] = pr[20:0];
         if (mag21(pr[20:0]) > 21'(ONE_Q))
            y.tir = 1'b1;
      end
      return y;
   endfunction

   function automatic pipe_type f_ps(input pipe_type x);
      pipe_type y;
      logic [20:0] m;
      logic [29:0] sq;
      y = x;
      for (int i = 0; i < 3; i++) begin
         m  = mag21(x.p[i]);
         sq = m[14:0] * m[14:0];
         y.pa[i] = prod_type'(sq);
      end
      return y;
   endfunction

   function automatic pipe_type f_k(input pipe_type x);
      pipe_type y;
      prod_type s;
      prod_type kk;
      y = x;
      s  = x.pa[0] + x.pa[1] + x.pa[2];
      kk = prod_type'(ONE_SQ) - s;
      if (s > prod_type'(ONE_SQ))
         y.tir = 1'b1;
      y.lsq  = kk[33:0];
      y.rem  = '0;
      y.root = '0;
      return y;
   endfunction

   function automatic pipe_type f_sn(input pipe_type x);
      pipe_type y;
      y = x;
      y.sqk = x.root[14:0];
      for (int i = 0; i < 3; i++)
         y.pa[i] = $signed({1'b0, x.root[14:0]}) * x.n[i];
      return y;
   endfunction

   function automatic pipe_type f_v(input pipe_type x);
      pipe_type y;
      logic signed [39:0] va;
      y = x;
      for (int i = 0; i < 3; i++) begin
         va = 40'(x.p[i]) - rnd_shr(40'(x.pa[i]));
         y.v[i] = va[17:0];
      end
      return y;
   endfunction

   function automatic pipe_type f_vs(input pipe_type x);
      pipe_type y;
      y = x;
      for (int i = 0; i < 3; i++)
         y.pa[i] = x.v[i] * x.v[i];
      return y;
   endfunction

   function automatic pipe_type f_l2(input pipe_type x);
      pipe_type y;
      prod_type s;
      y = x;
      s = x.pa[0] + x.pa[1] + x.pa[2];
      y.lsq  = s[33:0];
      y.dgn2 = (s <= prod_type'(SMALL_SQ));
      y.rem  = '0;
      y.root = '0;
      return y;
   endfunction

   function automatic pipe_type f_out(input pipe_type x);
      pipe_type y;
      s16_type qq;
      y = x;
      for (int i = 0; i < 3; i++) begin
         qq = {1'b0, x.q[i]};
         if (x.tir)
            y.res[i] = sat16(x.r[i]);
         else if (x.dgn2)
            y.res[i] = '0;
         else
            y.res[i] = (x.v[i] < 0) ? -qq : qq;
      end
      return y;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/vector_refract_with_reflect.sv]
// top level of the refraction / total reflection pipeline
// holds the stage registers and handshake; arithmetic per stage in vrr_pkg
//
//   channel  direction  ports                                        handshake
//   req      in         req_dir_*, req_norm_*, req_eta_ratio         req_valid/req_ready
//   rsp      out        rsp_out_*, rsp_total_reflect, rsp_degenerate_in  rsp_valid/rsp_ready
//
// one item per cycle while no output item waits; NS (98) register stages, among them
// three 17-stage square root chains and two 15-stage dividers
// reset clears only the stage valid bits
// all stages move together: when the output item waits, the pipe and req_ready
// hold, nothing is dropped or repeated
`default_nettype none

module vector_refract_with_reflect
   import vrr_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [15:0] req_dir_x,
   input  wire  [15:0] req_dir_y,
   input  wire  [15:0] req_dir_z,
   input  wire  [15:0] req_norm_x,
   input  wire  [15:0] req_norm_y,
   input  wire  [15:0] req_norm_z,
   input  wire  [15:0] req_eta_ratio,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [15:0] rsp_out_x,
   output logic [15:0] rsp_out_y,
   output logic [15:0] rsp_out_z,
   output logic        rsp_total_reflect,
   output logic        rsp_degenerate_in
);

   pipe_type st_ff [NS];
   pipe_type st_in [NS];
   pipe_type in_item;
   logic     adv;

   assign adv       = !st_ff[NS-1].vld || rsp_ready;
   assign req_ready = adv;

   always_comb begin
      in_item      = '0;
      in_item.vld  = req_valid;
      in_item.u[0] = req_dir_x;
      in_item.u[1] = req_dir_y;
      in_item.u[2] = req_dir_z;
      in_item.n[0] = req_norm_x;
      in_item.n[1] = req_norm_y;
      in_item.n[2] = req_norm_z;
      in_item.eta  = req_eta_ratio;
   end

   for (genvar gs = 0; gs < NS; gs++) begin : g_st
      pipe_type prv;

      if (gs == 0) begin : g_first
         assign prv = in_item;
      end else begin : g_next
         assign prv = st_ff[gs-1];
      end

      if (gs == S_IN) begin : g_in
         assign st_in[gs] = f_in(prv);
      end else if (gs == S_L1) begin : g_l1
         assign st_in[gs] = f_l1(prv);
      end else if (gs >= S_SQ1 && gs < S_D1) begin : g_sq1
         assign st_in[gs] = f_sqrt(prv, gs - S_SQ1);
      end else if (gs == S_D1) begin : g_d1
         assign st_in[gs] = f_d1(prv);
      end else if (gs >= S_DV1 && gs < S_UN) begin : g_dv1
         assign st_in[gs] = f_div(prv, DV_STEPS - 1 - (gs - S_DV1));
      end else if (gs == S_UN) begin : g_un
         assign st_in[gs] = f_un(prv);
      end else if (gs == S_DOT) begin : g_dot
         assign st_in[gs] = f_dot(prv);
      end else if (gs == S_CN) begin : g_cn
         assign st_in[gs] = f_cn(prv);
      end else if (gs == S_T) begin : g_t
         assign st_in[gs] = f_t(prv);
      end else if (gs == S_ET) begin : g_et
         assign st_in[gs] = f_et(prv);
      end else if (gs == S_P) begin : g_p
         assign st_in[gs] = f_p(prv);
      end else if (gs == S_PS) begin : g_ps
         assign st_in[gs] = f_ps(prv);
      end else if (gs == S_K) begin : g_k
         assign st_in[gs] = f_k(prv);
      end else if (gs >= S_SQ2 && gs < S_SN) begin : g_sq2
         assign st_in[gs] = f_sqrt(prv, gs - S_SQ2);
      end else if (gs == S_SN) begin : g_sn
         assign st_in[gs] = f_sn(prv);
      end else if (gs == S_V) begin : g_v
         assign st_in[gs] = f_v(prv);
      end else if (gs == S_VS) begin : g_vs
         assign st_in[gs] = f_vs(prv);
      end else if (gs == S_L2) begin : g_l2
         assign st_in[gs] = f_l2(prv);
      end else if (gs >= S_SQ3 && gs < S_D2) begin : g_sq3
         assign st_in[gs] = f_sqrt(prv, gs - S_SQ3);
      end else if (gs == S_D2) begin : g_d2
         assign st_in[gs] = f_d2(prv);
      end else if (gs >= S_DV2 && gs < S_OUT) begin : g_dv2
         assign st_in[gs] = f_div(prv, DV_STEPS - 1 - (gs - S_DV2));
      end else begin : g_out
         assign st_in[gs] = f_out(prv);
      end

      always_ff @(posedge clock) begin
         if (reset)
            st_ff[gs].vld <= 1'b0;
         else if (adv)
            st_ff[gs] <= st_in[gs];
      end
   end

   assign rsp_valid         = st_ff[NS-1].vld;
   assign rsp_out_x         = st_ff[NS-1].res[0];
   assign rsp_out_y         = st_ff[NS-1].res[1];
   assign rsp_out_z         = st_ff[NS-1].res[2];
   assign rsp_total_reflect = st_ff[NS-1].tir;
   assign rsp_degenerate_in = st_ff[NS-1].degen;

   // a waiting output item freezes the whole pipe
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("pipe not held while output item waits");

   // an accepted item lands in the first stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> st_ff[0].vld)
      else $error("accepted item lost at entry");

   // a refracted direction is unit length or zero, so no component exceeds one
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_total_reflect |->
         $signed(rsp_out_x) <= ONE_Q && $signed(rsp_out_x) >= -ONE_Q &&
         $signed(rsp_out_y) <= ONE_Q && $signed(rsp_out_y) >= -ONE_Q &&
         $signed(rsp_out_z) <= ONE_Q && $signed(rsp_out_z) >= -ONE_Q)
      else $error("refracted component out of unit range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

endmodule

`default_nettype wire
